// File: src/mfs_pkg.sv
// ----------------------------------------------------------------------------
// mfs_pkg
// Shared types and constants of the three-level feedback scheduler.
// ----------------------------------------------------------------------------
package mfs_pkg;

   localparam int JOB_W            = 3;
   localparam int FUNC_W           = 2;
   localparam int EV_W             = 3;
   localparam int LVL_W            = 2;
   localparam int RUN_W            = 4;
   localparam int CSR_IDX_W        = 2;
   localparam int DEFAULT_MAX_JOBS = 8;

   localparam logic [RUN_W-1:0] RUN_MAX            = 4'd15;
   localparam logic [RUN_W-1:0] HIGH_QUOTA_RESET   = 4'd2;
   localparam logic [RUN_W-1:0] MEDIUM_QUOTA_RESET = 4'd4;

   // event codes on the request side
   localparam logic [FUNC_W-1:0] FUNC_ADMIT     = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DISPATCH  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TIMESLICE = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_FINISH    = 2'd3;

   // result codes
   localparam logic [EV_W-1:0] EV_ON   = 3'd0;
   localparam logic [EV_W-1:0] EV_OFF  = 3'd1;
   localparam logic [EV_W-1:0] EV_FIN  = 3'd2;
   localparam logic [EV_W-1:0] EV_IDLE = 3'd3;
   localparam logic [EV_W-1:0] EV_ERR  = 3'd4;

   // queue levels
   localparam logic [LVL_W-1:0] LVL_HIGH   = 2'd0;
   localparam logic [LVL_W-1:0] LVL_MEDIUM = 2'd1;
   localparam logic [LVL_W-1:0] LVL_LOW    = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_HIGH_QUOTA   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MEDIUM_QUOTA = 2'd1;

   typedef struct packed {
      logic             admit;
      logic             count_run;
      logic             set_level;
      logic [JOB_W-1:0] job;
      logic [LVL_W-1:0] level;
   } mfs_tbl_cmd_type;

   typedef struct packed {
      logic [LVL_W-1:0] level;
      logic [RUN_W-1:0] high_runs;
      logic [RUN_W-1:0] medium_runs;
   } mfs_tbl_rd_type;

endpackage

// File: src/mfs_fifo.sv
// ----------------------------------------------------------------------------
// mfs_fifo
// Circular queue of job indices for one scheduling level.
// ----------------------------------------------------------------------------
module mfs_fifo #(
   parameter int DEPTH = mfs_pkg::DEFAULT_MAX_JOBS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic                     pop,
   input  logic [mfs_pkg::JOB_W-1:0] push_job,
   output logic [mfs_pkg::JOB_W-1:0] head_job,
   output logic                     empty,
   output logic                     full
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   logic [mfs_pkg::JOB_W-1:0] mem_ff [DEPTH];
   logic [IDX_W-1:0]          head_ff;
   logic [IDX_W-1:0]          head_in;
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic [SUM_W-1:0]          tail_sum;
   logic [IDX_W-1:0]          tail;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign head_job = mem_ff[head_ff];

   // head plus count stays below twice the depth
   always_comb begin
      tail_sum = SUM_W'(head_ff) + SUM_W'(count_ff);
      if (tail_sum >= SUM_W'(DEPTH)) begin
         tail_sum = tail_sum - SUM_W'(DEPTH);
      end
      tail = tail_sum[IDX_W-1:0];
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (pop && !empty) begin
         head_in  = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
         count_in = count_in - 1'b1;
      end
      if (push && !full) begin
         count_in = count_in + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         mem_ff[tail] <= push_job;
      end
   end

endmodule

// File: src/mfs_job_table.sv
// ----------------------------------------------------------------------------
// mfs_job_table
// Per-job level and run counters, one lane per job, one read port.
// ----------------------------------------------------------------------------
module mfs_job_table #(
   parameter int MAX_JOBS = mfs_pkg::DEFAULT_MAX_JOBS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  mfs_pkg::mfs_tbl_cmd_type  cmd,
   input  logic [mfs_pkg::JOB_W-1:0] rd_job,
   output mfs_pkg::mfs_tbl_rd_type   rd
);

   logic [mfs_pkg::LVL_W-1:0] levels_ff      [MAX_JOBS];
   logic [mfs_pkg::RUN_W-1:0] high_runs_ff   [MAX_JOBS];
   logic [mfs_pkg::RUN_W-1:0] medium_runs_ff [MAX_JOBS];

   // jobs outside the table read as level high with zero counts
   always_comb begin
      rd = '0;
      for (int i = 0; i < MAX_JOBS; i++) begin
         if (32'(rd_job) == i) begin
            rd.level       = levels_ff[i];
            rd.high_runs   = high_runs_ff[i];
            rd.medium_runs = medium_runs_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_JOBS; i++) begin
         if (reset) begin
            levels_ff[i]      <= mfs_pkg::LVL_HIGH;
            high_runs_ff[i]   <= '0;
            medium_runs_ff[i] <= '0;
         end else if (32'(cmd.job) == i) begin
            if (cmd.admit) begin
               levels_ff[i]      <= mfs_pkg::LVL_HIGH;
               high_runs_ff[i]   <= '0;
               medium_runs_ff[i] <= '0;
            end else if (cmd.count_run) begin
               if (cmd.level == mfs_pkg::LVL_HIGH && high_runs_ff[i] != mfs_pkg::RUN_MAX) begin
                  high_runs_ff[i] <= high_runs_ff[i] + 1'b1;
               end
               if (cmd.level == mfs_pkg::LVL_MEDIUM &&
                   medium_runs_ff[i] != mfs_pkg::RUN_MAX) begin
                  medium_runs_ff[i] <= medium_runs_ff[i] + 1'b1;
               end
            end else if (cmd.set_level) begin
               levels_ff[i] <= cmd.level;
            end
         end
      end
   end

endmodule

// File: src/multilevel_feedback_scheduler_unit.sv
// ----------------------------------------------------------------------------
// multilevel_feedback_scheduler_unit
// Three-level feedback scheduler: admit, dispatch, timeslice and finish events.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one event (func, job). It is taken at a clock edge where
//   req_valid is high and req_stall is low. Each event is decoded in the
//   cycle it is taken; its result sits in the rsp_* output register from the
//   next cycle on, and one event is taken per cycle while req_stall is low.
//   A successful admit produces no result; every other event produces one.
//   rsp_stall high holds the result; the block keeps taking events while the
//   output register is empty or being drained, and stalls req_ otherwise.
//   csr_* writes the two quota registers (index 0 high, 1 medium); it is
//   always ready and is meant to be used while no event is in flight.
//   Reset (synchronous) empties all queues, clears levels and run counters,
//   drops the running job and loads the quotas with 2 and 4.
// ----------------------------------------------------------------------------
module multilevel_feedback_scheduler_unit #(
   parameter int MAX_JOBS = mfs_pkg::DEFAULT_MAX_JOBS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [mfs_pkg::FUNC_W-1:0]    req_func,
   input  logic [mfs_pkg::JOB_W-1:0]     req_job,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [mfs_pkg::EV_W-1:0]      rsp_event_res,
   output logic [mfs_pkg::JOB_W-1:0]     rsp_job_index,
   output logic [mfs_pkg::LVL_W-1:0]     rsp_level,
   output logic                          rsp_demoted,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [mfs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mfs_pkg::RUN_W-1:0]     csr_wdata
);

   logic [mfs_pkg::RUN_W-1:0]  high_quota_ff;
   logic [mfs_pkg::RUN_W-1:0]  medium_quota_ff;
   logic [mfs_pkg::JOB_W-1:0]  run_job_ff;
   logic [mfs_pkg::JOB_W-1:0]  run_job_in;
   logic                       run_valid_ff;
   logic                       run_valid_in;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic [mfs_pkg::EV_W-1:0]   event_res_ff;
   logic [mfs_pkg::EV_W-1:0]   event_res_in;
   logic [mfs_pkg::JOB_W-1:0]  job_index_ff;
   logic [mfs_pkg::JOB_W-1:0]  job_index_in;
   logic [mfs_pkg::LVL_W-1:0]  level_ff;
   logic [mfs_pkg::LVL_W-1:0]  level_in;
   logic                       demoted_ff;
   logic                       demoted_in;

   logic                       accept;
   logic                       emit;
   logic [2:0]                 push;
   logic [2:0]                 pop;
   logic [2:0]                 empty;
   logic [2:0]                 full;
   logic [mfs_pkg::JOB_W-1:0]  head_job [3];
   logic [mfs_pkg::JOB_W-1:0]  push_job;
   logic [mfs_pkg::JOB_W-1:0]  rd_job;
   logic [mfs_pkg::LVL_W-1:0]  pick_lvl;
   logic [mfs_pkg::JOB_W-1:0]  pick_job;
   logic [mfs_pkg::LVL_W-1:0]  dest_lvl;
   logic                       dest_dem;
   logic                       dest_full;
   logic                       job_out_of_range;
   mfs_pkg::mfs_tbl_cmd_type   tbl_cmd;
   mfs_pkg::mfs_tbl_rd_type    tbl_rd;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_event_res = event_res_ff;
   assign rsp_job_index = job_index_ff;
   assign rsp_level     = level_ff;
   assign rsp_demoted   = demoted_ff;

   for (genvar l = 0; l < 3; l++) begin : g_level
      mfs_fifo #(
         .DEPTH (MAX_JOBS)
      ) u_fifo (
         .clock    (clock),
         .reset    (reset),
         .push     (push[l]),
         .pop      (pop[l]),
         .push_job (push_job),
         .head_job (head_job[l]),
         .empty    (empty[l]),
         .full     (full[l])
      );
   end

   mfs_job_table #(
      .MAX_JOBS (MAX_JOBS)
   ) u_job_table (
      .clock  (clock),
      .reset  (reset),
      .cmd    (tbl_cmd),
      .rd_job (rd_job),
      .rd     (tbl_rd)
   );

   assign rd_job           = (req_func == mfs_pkg::FUNC_ADMIT) ? req_job : run_job_ff;
   assign job_out_of_range = (32'(req_job) >= MAX_JOBS);

   // highest non-empty level for dispatch
   always_comb begin
      if (!empty[0]) begin
         pick_lvl = mfs_pkg::LVL_HIGH;
         pick_job = head_job[0];
      end else if (!empty[1]) begin
         pick_lvl = mfs_pkg::LVL_MEDIUM;
         pick_job = head_job[1];
      end else begin
         pick_lvl = mfs_pkg::LVL_LOW;
         pick_job = head_job[2];
      end
   end

   // where an expiring job goes back to
   always_comb begin
      dest_lvl = tbl_rd.level;
      dest_dem = 1'b0;
      if (tbl_rd.level == mfs_pkg::LVL_HIGH && tbl_rd.high_runs >= high_quota_ff) begin
         dest_lvl = mfs_pkg::LVL_MEDIUM;
         dest_dem = 1'b1;
      end else if (tbl_rd.level == mfs_pkg::LVL_MEDIUM &&
                   tbl_rd.medium_runs >= medium_quota_ff) begin
         dest_lvl = mfs_pkg::LVL_LOW;
         dest_dem = 1'b1;
      end
      case (dest_lvl)
         mfs_pkg::LVL_HIGH:   dest_full = full[0];
         mfs_pkg::LVL_MEDIUM: dest_full = full[1];
         default:             dest_full = full[2];
      endcase
   end

   always_comb begin
      push         = '0;
      pop          = '0;
      push_job     = run_job_ff;
      tbl_cmd      = '0;
      tbl_cmd.job  = run_job_ff;
      run_job_in   = run_job_ff;
      run_valid_in = run_valid_ff;
      emit         = 1'b1;
      // error result by default
      event_res_in = mfs_pkg::EV_ERR;
      job_index_in = run_job_ff;
      level_in     = tbl_rd.level;
      demoted_in   = 1'b0;
      case (req_func)
         mfs_pkg::FUNC_ADMIT: begin
            job_index_in = req_job;
            if (!job_out_of_range && !full[0]) begin
               emit          = 1'b0;
               push[0]       = 1'b1;
               push_job      = req_job;
               tbl_cmd.admit = 1'b1;
               tbl_cmd.job   = req_job;
            end
         end
         mfs_pkg::FUNC_DISPATCH: begin
            if (!run_valid_ff) begin
               if (&empty) begin
                  event_res_in = mfs_pkg::EV_IDLE;
                  job_index_in = '0;
                  level_in     = mfs_pkg::LVL_HIGH;
               end else begin
                  case (pick_lvl)
                     mfs_pkg::LVL_HIGH:   pop[0] = 1'b1;
                     mfs_pkg::LVL_MEDIUM: pop[1] = 1'b1;
                     default:             pop[2] = 1'b1;
                  endcase
                  run_job_in        = pick_job;
                  run_valid_in      = 1'b1;
                  tbl_cmd.count_run = 1'b1;
                  tbl_cmd.job       = pick_job;
                  tbl_cmd.level     = pick_lvl;
                  event_res_in      = mfs_pkg::EV_ON;
                  job_index_in      = pick_job;
                  level_in          = pick_lvl;
               end
            end
         end
         mfs_pkg::FUNC_TIMESLICE: begin
            if (run_valid_ff && !dest_full) begin
               case (dest_lvl)
                  mfs_pkg::LVL_HIGH:   push[0] = 1'b1;
                  mfs_pkg::LVL_MEDIUM: push[1] = 1'b1;
                  default:             push[2] = 1'b1;
               endcase
               tbl_cmd.set_level = 1'b1;
               tbl_cmd.level     = dest_lvl;
               run_valid_in      = 1'b0;
               event_res_in      = mfs_pkg::EV_OFF;
               level_in          = dest_lvl;
               demoted_in        = dest_dem;
            end
         end
         default: begin
            if (run_valid_ff) begin
               run_valid_in = 1'b0;
               event_res_in = mfs_pkg::EV_FIN;
            end
         end
      endcase
      if (!accept) begin
         push         = '0;
         pop          = '0;
         tbl_cmd      = '0;
         run_job_in   = run_job_ff;
         run_valid_in = run_valid_ff;
         emit         = 1'b0;
      end
   end

   // output register: load on a new result, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff    <= 1'b0;
         run_valid_ff    <= 1'b0;
         run_job_ff      <= '0;
         high_quota_ff   <= mfs_pkg::HIGH_QUOTA_RESET;
         medium_quota_ff <= mfs_pkg::MEDIUM_QUOTA_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         run_valid_ff <= run_valid_in;
         run_job_ff   <= run_job_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               mfs_pkg::REG_HIGH_QUOTA:   high_quota_ff   <= csr_wdata;
               mfs_pkg::REG_MEDIUM_QUOTA: medium_quota_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         event_res_ff <= event_res_in;
         job_index_ff <= job_index_in;
         level_ff     <= level_in;
         demoted_ff   <= demoted_in;
      end
   end

endmodule

// File: tb/multilevel_feedback_scheduler_unit_tb.sv
// ----------------------------------------------------------------------------
// multilevel_feedback_scheduler_unit_tb
// Checks the three-level feedback scheduler against a cycle-free model of its
// queues, levels and run counters. Beats go in through req_, results are
// matched in order on rsp_, and the quotas are rewritten between phases.
// ----------------------------------------------------------------------------
module multilevel_feedback_scheduler_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int              CYCLE_LIMIT = 300000;
   localparam int              SETTLE      = 4;
   localparam logic [3:0]      LANE_DEPTH  = 4'd8;
   localparam logic [mfs_pkg::CSR_IDX_W-1:0] REG_SPARE = 2'd3;

   typedef struct packed {
      logic [mfs_pkg::FUNC_W-1:0] func;
      logic [mfs_pkg::JOB_W-1:0]  job;
   } sched_item_type;

   typedef struct packed {
      logic [mfs_pkg::EV_W-1:0]  event_res;
      logic [mfs_pkg::JOB_W-1:0] job_index;
      logic [mfs_pkg::LVL_W-1:0] level;
      logic                      demoted;
   } sched_result_type;

   logic                          clock     = 1'b0;
   logic                          reset     = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [mfs_pkg::FUNC_W-1:0]    req_func  = '0;
   logic [mfs_pkg::JOB_W-1:0]     req_job   = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [mfs_pkg::EV_W-1:0]      rsp_event_res;
   logic [mfs_pkg::JOB_W-1:0]     rsp_job_index;
   logic [mfs_pkg::LVL_W-1:0]     rsp_level;
   logic                          rsp_demoted;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [mfs_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [mfs_pkg::RUN_W-1:0]     csr_wdata = '0;

   multilevel_feedback_scheduler_unit i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_job       (req_job),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_event_res (rsp_event_res),
      .rsp_job_index (rsp_job_index),
      .rsp_level     (rsp_level),
      .rsp_demoted   (rsp_demoted),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // scheduler model state
   logic [mfs_pkg::JOB_W-1:0] lane_store [3][8];
   logic [mfs_pkg::JOB_W-1:0] lane_head [3];
   logic [3:0]                lane_count [3];
   logic [mfs_pkg::LVL_W-1:0] job_level [8];
   logic [mfs_pkg::RUN_W-1:0] runs_at_high [8];
   logic [mfs_pkg::RUN_W-1:0] runs_at_medium [8];
   logic [mfs_pkg::JOB_W-1:0] running_job;
   logic                      running_valid;
   logic [mfs_pkg::RUN_W-1:0] quota_high;
   logic [mfs_pkg::RUN_W-1:0] quota_medium;

   sched_item_type   event_backlog [$];
   sched_result_type scheduler_results [$];
   int               error_count = 0;
   int               cycle_count = 0;
   int               send_gap    = 0;
   int               stall_gap   = 0;
   bit               quiet       = 1'b0;

   sched_item_type   taken_item;
   sched_item_type   next_item;
   sched_result_type predicted;
   sched_result_type wanted;
   bit               produced;

   function automatic sched_result_type make_result(logic [mfs_pkg::EV_W-1:0] ev,
                                                    logic [mfs_pkg::JOB_W-1:0] j,
                                                    logic [mfs_pkg::LVL_W-1:0] lvl,
                                                    logic dem);
      sched_result_type r;
      r.event_res = ev;
      r.job_index = j;
      r.level     = lvl;
      r.demoted   = dem;
      return r;
   endfunction

   function automatic bit lane_push(int lane, logic [mfs_pkg::JOB_W-1:0] j);
      logic [mfs_pkg::JOB_W-1:0] tail;
      if (lane_count[lane] == LANE_DEPTH) return 1'b0;
      tail = lane_head[lane] + lane_count[lane][mfs_pkg::JOB_W-1:0];
      lane_store[lane][tail] = j;
      lane_count[lane] = lane_count[lane] + 1'b1;
      return 1'b1;
   endfunction

   task automatic schedule_event(input sched_item_type item, output bit has_result,
                                 output sched_result_type outcome);
      logic [mfs_pkg::JOB_W-1:0] j;
      logic [mfs_pkg::LVL_W-1:0] dest;
      logic                      dem;
      int                        lane;
      has_result = 1'b1;
      outcome = '0;
      case (item.func)
         mfs_pkg::FUNC_ADMIT: begin
            j = item.job;
            if (!lane_push(int'(mfs_pkg::LVL_HIGH), j)) begin
               outcome = make_result(mfs_pkg::EV_ERR, j, job_level[j], 1'b0);
            end else begin
               job_level[j]      = mfs_pkg::LVL_HIGH;
               runs_at_high[j]   = '0;
               runs_at_medium[j] = '0;
               has_result        = 1'b0;
            end
         end
         mfs_pkg::FUNC_DISPATCH: begin
            if (running_valid) begin
               outcome = make_result(mfs_pkg::EV_ERR, running_job,
                                     job_level[running_job], 1'b0);
            end else begin
               lane = 0;
               while (lane < 3 && lane_count[lane] == 0) lane++;
               if (lane == 3) begin
                  outcome = make_result(mfs_pkg::EV_IDLE, '0, mfs_pkg::LVL_HIGH, 1'b0);
               end else begin
                  j = lane_store[lane][lane_head[lane]];
                  lane_head[lane]  = lane_head[lane] + 1'b1;
                  lane_count[lane] = lane_count[lane] - 1'b1;
                  running_job   = j;
                  running_valid = 1'b1;
                  // counted at the level of the queue it came from
                  if (lane == int'(mfs_pkg::LVL_HIGH) && runs_at_high[j] != mfs_pkg::RUN_MAX)
                     runs_at_high[j] = runs_at_high[j] + 1'b1;
                  if (lane == int'(mfs_pkg::LVL_MEDIUM) &&
                      runs_at_medium[j] != mfs_pkg::RUN_MAX)
                     runs_at_medium[j] = runs_at_medium[j] + 1'b1;
                  outcome = make_result(mfs_pkg::EV_ON, j, lane[mfs_pkg::LVL_W-1:0], 1'b0);
               end
            end
         end
         default: begin
            j = running_job;
            if (!running_valid) begin
               outcome = make_result(mfs_pkg::EV_ERR, j, job_level[j], 1'b0);
            end else if (item.func == mfs_pkg::FUNC_TIMESLICE) begin
               dest = job_level[j];
               dem  = 1'b0;
               if (job_level[j] == mfs_pkg::LVL_HIGH && runs_at_high[j] >= quota_high) begin
                  dest = mfs_pkg::LVL_MEDIUM;
                  dem  = 1'b1;
               end else if (job_level[j] == mfs_pkg::LVL_MEDIUM &&
                            runs_at_medium[j] >= quota_medium) begin
                  dest = mfs_pkg::LVL_LOW;
                  dem  = 1'b1;
               end
               if (!lane_push(int'(dest), j)) begin
                  // target queue full, job keeps running
                  outcome = make_result(mfs_pkg::EV_ERR, j, job_level[j], 1'b0);
               end else begin
                  job_level[j]  = dest;
                  running_valid = 1'b0;
                  outcome = make_result(mfs_pkg::EV_OFF, j, dest, dem);
               end
            end else begin
               running_valid = 1'b0;
               outcome = make_result(mfs_pkg::EV_FIN, j, job_level[j], 1'b0);
            end
         end
      endcase
   endtask

   task automatic note_failure(input string msg);
      error_count++;
      if (error_count <= 10) $display("%s", msg);
   endtask

   task automatic add_event(input logic [mfs_pkg::FUNC_W-1:0] func,
                            input logic [mfs_pkg::JOB_W-1:0] job);
      sched_item_type item;
      item.func = func;
      item.job  = job;
      event_backlog.push_back(item);
   endtask

   // driver: request beats come from the backlog
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            taken_item.func = req_func;
            taken_item.job  = req_job;
            schedule_event(taken_item, produced, predicted);
            if (produced) scheduler_results.push_back(predicted);
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (event_backlog.size() == 0) begin
               req_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(0, 6);
               req_valid <= 1'b0;
            end else begin
               next_item = event_backlog.pop_front();
               req_valid <= 1'b1;
               req_func  <= next_item.func;
               req_job   <= next_item.job;
            end
         end
      end
   end

   // monitor: result beats checked in order, stall driven in bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (scheduler_results.size() == 0) begin
               note_failure($sformatf("unexpected result: ev %0d job %0d level %0d demoted %0d",
                                      rsp_event_res, rsp_job_index, rsp_level, rsp_demoted));
            end else begin
               wanted = scheduler_results.pop_front();
               if (rsp_event_res !== wanted.event_res || rsp_job_index !== wanted.job_index ||
                   rsp_level !== wanted.level || rsp_demoted !== wanted.demoted)
                  note_failure($sformatf(
                     "mismatch: expected ev %0d job %0d level %0d demoted %0d, got %0d %0d %0d %0d",
                     wanted.event_res, wanted.job_index, wanted.level, wanted.demoted,
                     rsp_event_res, rsp_job_index, rsp_level, rsp_demoted));
            end
         end
         if (stall_gap > 0) begin
            stall_gap--;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_gap = $urandom_range(0, 6);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("multilevel_feedback_scheduler_unit_tb: errors");
         $finish;
      end
   end

   // csr_valid stays high across the three writes
   task automatic set_quotas(input logic [mfs_pkg::RUN_W-1:0] hq,
                             input logic [mfs_pkg::RUN_W-1:0] mq);
      csr_valid <= 1'b1;
      csr_index <= mfs_pkg::REG_HIGH_QUOTA;
      csr_wdata <= hq;
      do @(posedge clock); while (!csr_ready);
      quota_high = hq;
      csr_index <= mfs_pkg::REG_MEDIUM_QUOTA;
      csr_wdata <= mq;
      do @(posedge clock); while (!csr_ready);
      quota_medium = mq;
      // unused index, must change nothing
      csr_index <= REG_SPARE;
      csr_wdata <= mfs_pkg::RUN_W'($urandom_range(0, 15));
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (event_backlog.size() != 0 || req_valid || scheduler_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic queue_directed();
      int k;
      add_event(mfs_pkg::FUNC_DISPATCH, 3'd7);    // nothing queued: idle
      add_event(mfs_pkg::FUNC_TIMESLICE, 3'd0);   // nothing running
      add_event(mfs_pkg::FUNC_FINISH, 3'd7);
      for (k = 0; k < 8; k++) add_event(mfs_pkg::FUNC_ADMIT, 3'd7);
      add_event(mfs_pkg::FUNC_ADMIT, 3'd0);       // high queue full
      add_event(mfs_pkg::FUNC_DISPATCH, 3'd0);
      add_event(mfs_pkg::FUNC_DISPATCH, 3'd0);    // already running
      // first expiry demotes, the rest refill medium with the same job
      for (k = 0; k < 8; k++) begin
         if (k > 0) add_event(mfs_pkg::FUNC_DISPATCH, 3'd7);
         add_event(mfs_pkg::FUNC_TIMESLICE, 3'd0);
      end
      add_event(mfs_pkg::FUNC_ADMIT, 3'd0);
      add_event(mfs_pkg::FUNC_DISPATCH, 3'd0);
      add_event(mfs_pkg::FUNC_TIMESLICE, 3'd7);   // medium queue full
      add_event(mfs_pkg::FUNC_FINISH, 3'd0);
   endtask

   task automatic queue_random(input int count, input int admit_weight);
      int made;
      int roll;
      made = 0;
      while (made < count) begin
         roll = $urandom_range(0, 99);
         if (roll < admit_weight) begin
            add_event(mfs_pkg::FUNC_ADMIT, mfs_pkg::JOB_W'($urandom_range(0, 7)));
            made += 1;
         end else if (roll < 90) begin
            add_event(mfs_pkg::FUNC_DISPATCH, mfs_pkg::JOB_W'($urandom_range(0, 7)));
            add_event(($urandom_range(0, 3) == 0) ? mfs_pkg::FUNC_FINISH :
                                                    mfs_pkg::FUNC_TIMESLICE,
                      mfs_pkg::JOB_W'($urandom_range(0, 7)));
            made += 2;
         end else begin
            add_event(mfs_pkg::FUNC_W'($urandom_range(0, 3)),
                      mfs_pkg::JOB_W'($urandom_range(0, 7)));
            made += 1;
         end
      end
   endtask

   task automatic run_phase(input logic [mfs_pkg::RUN_W-1:0] hq,
                            input logic [mfs_pkg::RUN_W-1:0] mq,
                            input int admit_weight, input int count);
      set_quotas(hq, mq);
      queue_random(count, admit_weight);
      wait_drained();
   endtask

   initial begin
      for (int l = 0; l < 3; l++) begin
         lane_head[l]  = '0;
         lane_count[l] = '0;
         for (int e = 0; e < 8; e++) lane_store[l][e] = '0;
      end
      for (int j = 0; j < 8; j++) begin
         job_level[j]      = mfs_pkg::LVL_HIGH;
         runs_at_high[j]   = '0;
         runs_at_medium[j] = '0;
      end
      running_job   = '0;
      running_valid = 1'b0;
      quota_high    = mfs_pkg::HIGH_QUOTA_RESET;
      quota_medium  = mfs_pkg::MEDIUM_QUOTA_RESET;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      set_quotas(4'd1, 4'd15);
      queue_directed();
      wait_drained();

      run_phase(4'd2, 4'd4, 30, 250);
      run_phase(4'd15, 4'd15, 40, 250);
      run_phase(4'd0, 4'd0, 30, 240);
      run_phase(4'd1, 4'd1, 35, 250);
      run_phase(4'd15, 4'd1, 25, 200);
      run_phase(4'd3, 4'd9, 30, 250);
      quiet = 1'b1;
      run_phase(mfs_pkg::HIGH_QUOTA_RESET, mfs_pkg::MEDIUM_QUOTA_RESET, 30, 250);

      if (error_count == 0) begin
         $display("multilevel_feedback_scheduler_unit_tb: clean");
      end else begin
         $display("multilevel_feedback_scheduler_unit_tb: errors");
      end
      $finish;
   end

endmodule
